// File: src/navtex_message_framer_unit_macros.svh
// Assertion macros shared by the NAVTEX message framer checker.
`ifndef NAVTEX_MESSAGE_FRAMER_UNIT_MACROS_SVH
`define NAVTEX_MESSAGE_FRAMER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define NMF_ASSERT_NOW(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define NMF_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// File: src/nmf_pkg.sv
// Shared types, character codes and packing for the NAVTEX message framer.
package nmf_pkg;

  localparam logic [7:0] CH_Z  = 8'h5A;
  localparam logic [7:0] CH_C  = 8'h43;
  localparam logic [7:0] CH_N  = 8'h4E;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_0  = 8'h30;

  localparam int unsigned RES_BITS   = 35;
  localparam int unsigned TDATA_BITS = 40;

  typedef struct packed {
    logic       info_changed;
    logic       serial_valid;
    logic [6:0] serial_number;
    logic [7:0] subject_id;
    logic [7:0] station_id;
    logic       msg_complete;
    logic       msg_open;
    logic [7:0] char_echo;
  } result_t;

  function automatic logic [TDATA_BITS-1:0] pack_result(input result_t r);
    pack_result = {{(TDATA_BITS - RES_BITS){1'b0}}, r};
  endfunction

endpackage

// File: src/nmf_in_stage.sv
// Input register stage: holds one accepted character until the framer takes it.
module nmf_in_stage
  import nmf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_in
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_char
);

  assign s_tready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (s_tready) begin
      held_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      held_char <= s_tdata;
    end
  end

endmodule

// File: src/nmf_state.sv
// Message framing state and the per-character update that produces one result.
module nmf_state
  import nmf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] char_in,
  output result_t    res
);

  // Only the three newest window bytes are kept; the oldest drops out on the shift.
  logic [7:0] recent [3];
  logic       inside_flag, inside_flag_next;
  logic       done_flag, done_flag_next;
  logic [7:0] station_reg, station_reg_next;
  logic [7:0] subject_reg, subject_reg_next;
  logic [6:0] serial_reg, serial_reg_next;
  logic       serial_ok, serial_ok_next;
  logic [2:0] header_count, header_count_next;
  logic [7:0] header_chars [3];

  logic       hdr_we;
  logic       win_zczc, win_nnnn, is_blank;
  logic [7:0] d1, d2;
  logic [6:0] serial_calc;

  assign win_zczc = (recent[0] == CH_Z) && (recent[1] == CH_C) &&
                    (recent[2] == CH_Z) && (char_in == CH_C);
  assign win_nnnn = (recent[0] == CH_N) && (recent[1] == CH_N) &&
                    (recent[2] == CH_N) && (char_in == CH_N);
  assign is_blank = (char_in == CH_SP) || (char_in == CH_CR) || (char_in == CH_LF);

  assign d1 = header_chars[2] - CH_0;
  assign d2 = char_in - CH_0;
  assign serial_calc = {d1[3:0], 3'b000} + {2'b00, d1[3:0], 1'b0} + {3'b000, d2[3:0]};

  always_comb begin
    inside_flag_next  = inside_flag;
    done_flag_next    = done_flag;
    station_reg_next  = station_reg;
    subject_reg_next  = subject_reg;
    serial_reg_next   = serial_reg;
    serial_ok_next    = serial_ok;
    header_count_next = header_count;
    hdr_we            = 1'b0;
    if (win_zczc) begin
      inside_flag_next  = 1'b1;
      done_flag_next    = 1'b0;
      station_reg_next  = '0;
      subject_reg_next  = '0;
      serial_reg_next   = '0;
      serial_ok_next    = 1'b0;
      header_count_next = '0;
    end else if (win_nnnn && inside_flag) begin
      done_flag_next   = 1'b1;
      inside_flag_next = 1'b0;
    end else if (inside_flag && (header_count < 3'd4) && !is_blank) begin
      if (header_count < 3'd3) begin
        hdr_we            = 1'b1;
        header_count_next = header_count + 3'd1;
      end else begin
        header_count_next = 3'd4;
        station_reg_next  = header_chars[0];
        subject_reg_next  = header_chars[1];
        if ((d1 <= 8'd9) && (d2 <= 8'd9)) begin
          serial_reg_next = serial_calc;
          serial_ok_next  = 1'b1;
        end
      end
    end

    res.char_echo     = char_in;
    res.msg_open      = inside_flag_next;
    res.msg_complete  = done_flag_next;
    res.station_id    = station_reg_next;
    res.subject_id    = subject_reg_next;
    res.serial_number = serial_reg_next;
    res.serial_valid  = serial_ok_next;
    res.info_changed  = (inside_flag_next != inside_flag) || (done_flag_next != done_flag) ||
                        (station_reg_next != station_reg) ||
                        (subject_reg_next != subject_reg) ||
                        (serial_reg_next != serial_reg) || (serial_ok_next != serial_ok);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      recent[0]    <= '0;
      recent[1]    <= '0;
      recent[2]    <= '0;
      inside_flag  <= 1'b0;
      done_flag    <= 1'b0;
      station_reg  <= '0;
      subject_reg  <= '0;
      serial_reg   <= '0;
      serial_ok    <= 1'b0;
      header_count <= '0;
    end else if (step) begin
      recent[0]    <= recent[1];
      recent[1]    <= recent[2];
      recent[2]    <= char_in;
      inside_flag  <= inside_flag_next;
      done_flag    <= done_flag_next;
      station_reg  <= station_reg_next;
      subject_reg  <= subject_reg_next;
      serial_reg   <= serial_reg_next;
      serial_ok    <= serial_ok_next;
      header_count <= header_count_next;
    end
  end

  // Header bytes are read only after being written in the same message.
  always_ff @(posedge clk) begin
    if (step && hdr_we) begin
      header_chars[header_count[1:0]] <= char_in;
    end
  end

endmodule

// File: src/navtex_message_framer_unit.sv
// NAVTEX message framer: one request in, one result out, one character per clock.
// Each character request gives exactly one result request carrying the echoed
// character, the ZCZC/NNNN message state, the captured header and a change flag.
// The block sustains one character per cycle while the downstream side is ready.
// An accepted character request passes through the input register, then the result
// register, before its result is presented. The framing state is a single
// register loop updated as a character moves from the input register into the
// result register. While a finished result waits for the downstream side, the
// input register can take one more character; after that the input side stalls
// until the result is taken.
module navtex_message_framer_unit
  import nmf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,  // [7:0] char_in
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [7:0] char_echo, [8] msg_open, [9] msg_complete, [17:10] station_id,
  // [25:18] subject_id, [32:26] serial_number, [33] serial_valid,
  // [34] info_changed, [39:35] zero
  output logic [TDATA_BITS-1:0] m_tdata
);

  logic       held_valid;
  logic [7:0] held_char;
  logic       advance;
  result_t    res;

  assign advance = held_valid && (!m_tvalid || m_tready);

  nmf_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .take       (advance),
    .held_valid (held_valid),
    .held_char  (held_char)
  );

  nmf_state u_state (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .char_in (held_char),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= pack_result(res);
    end
  end

endmodule

// File: src/nmf_checker.sv
// Port-level checks for the NAVTEX message framer, bound to the top level.
`include "navtex_message_framer_unit_macros.svh"

module nmf_checker
  import nmf_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [TDATA_BITS-1:0] m_tdata
);

  logic       out_stall;
  logic       msg_open, msg_done, ser_ok;
  logic [6:0] ser_num;

  assign out_stall = m_tvalid && !m_tready;
  assign msg_open  = m_tdata[8];
  assign msg_done  = m_tdata[9];
  assign ser_num   = m_tdata[32:26];
  assign ser_ok    = m_tdata[33];

  // A stalled result request keeps its payload.
  `NMF_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(m_tdata), "stalled result changed")
  // A message cannot be open and closed at the same time.
  `NMF_ASSERT_NOW(a_state_excl, m_tvalid, !(msg_open && msg_done), "open and complete both set")
  `NMF_ASSERT_NOW(a_serial_zero, m_tvalid && !ser_ok, ser_num == 7'd0, "invalid serial not zero")
  `NMF_ASSERT_NOW(a_serial_range, m_tvalid, ser_num <= 7'd99, "serial above 99")

endmodule

bind navtex_message_framer_unit nmf_checker u_nmf_checker (.*);

// File: verif/tb.sv
// Self-checking testbench for the NAVTEX message framer unit.
module tb;
  import nmf_pkg::*;

  localparam int unsigned RANDOM_CHARS = 1420;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam logic [7:0]  CH_A         = 8'h41;

  typedef struct {
    logic [7:0] ch;
    bit         typed;
    result_t    want;
  } char_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = 8'h00;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [TDATA_BITS-1:0] m_tdata;

  char_row_t char_plan[$];
  result_t   framing_q[$];
  int        mismatch_count = 0;
  int        results_seen = 0;

  // Mirror of the framing state.
  logic [7:0] recent_win[4] = '{default: 8'h00};
  logic       in_msg_st = 1'b0;
  logic       done_st = 1'b0;
  logic [7:0] station_st = 8'h00;
  logic [7:0] subject_st = 8'h00;
  logic [6:0] serial_st = 7'd0;
  logic       serial_ok_st = 1'b0;
  logic [2:0] hdr_cnt = 3'd0;
  logic [7:0] hdr_buf[3] = '{default: 8'h00};

  navtex_message_framer_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic result_t framer_predict(input logic [7:0] c);
    result_t    r;
    logic       prev_in, prev_done, prev_ok;
    logic [7:0] prev_sta, prev_sub;
    logic [6:0] prev_ser;
    logic [7:0] d1, d2, ser_sum;
    logic       zczc, nnnn;
    prev_in   = in_msg_st;
    prev_done = done_st;
    prev_ok   = serial_ok_st;
    prev_sta  = station_st;
    prev_sub  = subject_st;
    prev_ser  = serial_st;
    recent_win[0] = recent_win[1];
    recent_win[1] = recent_win[2];
    recent_win[2] = recent_win[3];
    recent_win[3] = c;
    zczc = recent_win[0] == CH_Z && recent_win[1] == CH_C &&
           recent_win[2] == CH_Z && recent_win[3] == CH_C;
    nnnn = recent_win[0] == CH_N && recent_win[1] == CH_N &&
           recent_win[2] == CH_N && recent_win[3] == CH_N;
    if (zczc) begin
      in_msg_st    = 1'b1;
      done_st      = 1'b0;
      station_st   = 8'h00;
      subject_st   = 8'h00;
      serial_st    = 7'd0;
      serial_ok_st = 1'b0;
      hdr_cnt      = 3'd0;
    end else if (nnnn && in_msg_st) begin
      done_st   = 1'b1;
      in_msg_st = 1'b0;
    end else if (in_msg_st && hdr_cnt < 3'd4) begin
      if (c != CH_SP && c != CH_CR && c != CH_LF) begin
        if (hdr_cnt < 3'd3) begin
          hdr_buf[hdr_cnt] = c;
          hdr_cnt = hdr_cnt + 3'd1;
        end else begin
          // The serial counts only when both characters are decimal digits.
          d1 = hdr_buf[2] - CH_0;
          d2 = c - CH_0;
          hdr_cnt    = 3'd4;
          station_st = hdr_buf[0];
          subject_st = hdr_buf[1];
          if (d1 <= 8'd9 && d2 <= 8'd9) begin
            ser_sum      = d1 * 8'd10 + d2;
            serial_st    = ser_sum[6:0];
            serial_ok_st = 1'b1;
          end
        end
      end
    end
    r.char_echo     = c;
    r.msg_open      = in_msg_st;
    r.msg_complete  = done_st;
    r.station_id    = station_st;
    r.subject_id    = subject_st;
    r.serial_number = serial_st;
    r.serial_valid  = serial_ok_st;
    r.info_changed  = in_msg_st != prev_in || done_st != prev_done ||
                      station_st != prev_sta || subject_st != prev_sub ||
                      serial_st != prev_ser || serial_ok_st != prev_ok;
    return r;
  endfunction

  function automatic void add_char(input logic [7:0] ch, input bit typed = 1'b0,
                                   input result_t want = '0);
    char_row_t row;
    row.ch    = ch;
    row.typed = typed;
    row.want  = want;
    char_plan.insert(char_plan.size(), row);
  endfunction

  function automatic void add_zczc();
    add_char(CH_Z);
    add_char(CH_C);
    add_char(CH_Z);
    add_char(CH_C);
  endfunction

  function automatic void add_nnnn();
    repeat (4) add_char(CH_N);
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 2))
      0:       return CH_SP;
      1:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  function automatic logic [7:0] body_char();
    case ($urandom_range(0, 7))
      0:       return 8'($urandom_range(0, 255));
      1:       return blank_char();
      2:       return CH_N;
      default: return CH_A + 8'($urandom_range(0, 25));
    endcase
  endfunction

  function automatic logic [7:0] header_letter();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return CH_A + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] serial_char();
    if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
    return CH_0 + 8'($urandom_range(0, 9));
  endfunction

  // Mostly well-formed messages with random content, mixed with noise
  // and sequences that break off part way.
  function automatic void build_random_plan();
    int stop_at;
    int body_len;
    stop_at = char_plan.size() + RANDOM_CHARS;
    while (char_plan.size() < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          add_zczc();
          repeat ($urandom_range(0, 3)) add_char(blank_char());
          add_char(header_letter());
          if ($urandom_range(0, 3) == 0) add_char(blank_char());
          add_char(header_letter());
          add_char(serial_char());
          if ($urandom_range(0, 5) == 0) add_char(blank_char());
          add_char(serial_char());
          body_len = $urandom_range(0, 20);
          repeat (body_len) add_char(body_char());
          if ($urandom_range(0, 5) != 0) add_nnnn();
        end
        7: repeat ($urandom_range(1, 10)) add_char(8'($urandom_range(0, 255)));
        8: begin
          if ($urandom_range(0, 1) == 0) begin
            add_char(CH_Z);
            add_char(CH_C);
            add_char(CH_Z);
          end else begin
            repeat (3) add_char(CH_N);
          end
          add_char(body_char());
        end
        default: add_nnnn();
      endcase
    end
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_result(input logic [TDATA_BITS-1:0] data);
    result_t got, want;
    got = result_t'(data[RES_BITS-1:0]);
    if (framing_q.size() == 0) begin
      $display("%0t: result with no request pending, actual %0h", $realtime, data);
      mismatch_count++;
    end else begin
      want = framing_q.pop_front();
      check_field("char_echo", want.char_echo, got.char_echo);
      check_field("msg_open", want.msg_open, got.msg_open);
      check_field("msg_complete", want.msg_complete, got.msg_complete);
      check_field("station_id", want.station_id, got.station_id);
      check_field("subject_id", want.subject_id, got.subject_id);
      check_field("serial_number", want.serial_number, got.serial_number);
      check_field("serial_valid", want.serial_valid, got.serial_valid);
      check_field("info_changed", want.info_changed, got.info_changed);
    end
  endtask

  // Downstream side: random stall before each result, with calm stretches.
  initial begin
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = ((results_seen / 60) % 4 == 3) ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      check_result(m_tdata);
      results_seen++;
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int      gap;
    result_t predicted;
    // Directed part: reset state, window restarts, header capture, extremes.
    add_char(8'h00, 1'b1, '0);
    add_char(CH_Z);
    add_char(CH_C);
    add_char(CH_Z);
    add_char(CH_C, 1'b1, '{info_changed: 1'b1, serial_valid: 1'b0, serial_number: 7'd0,
                           subject_id: 8'h00, station_id: 8'h00, msg_complete: 1'b0,
                           msg_open: 1'b1, char_echo: CH_C});
    add_char(CH_SP);
    add_char(CH_CR);
    add_char(CH_LF);
    add_char(8'h53);
    add_char(CH_A);
    add_char(CH_0 + 8'd1);
    add_char(CH_0 + 8'd2, 1'b1, '{info_changed: 1'b1, serial_valid: 1'b1,
                                  serial_number: 7'd12, subject_id: CH_A,
                                  station_id: 8'h53, msg_complete: 1'b0,
                                  msg_open: 1'b1, char_echo: CH_0 + 8'd2});
    // Restart inside a message, then NNNN whose leading characters fill the header.
    add_zczc();
    repeat (3) add_char(CH_N);
    add_char(CH_N, 1'b1, '{info_changed: 1'b1, serial_valid: 1'b0, serial_number: 7'd0,
                           subject_id: 8'h00, station_id: 8'h00, msg_complete: 1'b1,
                           msg_open: 1'b0, char_echo: CH_N});
    // A fifth N keeps NNNN in the window while outside a message.
    add_char(CH_N);
    // Non-digit serial with an extreme subject byte.
    add_zczc();
    add_char(8'h42);
    add_char(8'hFF);
    add_char(CH_0 + 8'd9);
    add_char(8'h51);
    build_random_plan();

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < char_plan.size(); i++) begin
      gap = ((i / 50) % 5 == 4) ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= char_plan[i].ch;
      do @(posedge clk); while (!s_tready);
      predicted = framer_predict(char_plan[i].ch);
      framing_q.insert(framing_q.size(), char_plan[i].typed ? char_plan[i].want : predicted);
    end
    s_tvalid <= 1'b0;

    while (framing_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
